/* rtl/core/contact_tracker_least_used_color_core_defines.svh */
// assertion macros for the contact tracker core
`ifndef CONTACT_TRACKER_LEAST_USED_COLOR_CORE_DEFINES_SVH
`define CONTACT_TRACKER_LEAST_USED_COLOR_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define CT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ctluc_pkg.sv */
// ----------------------------------------------------------------------------
// ctluc_pkg
// shared types and codes of the contact tracker core
// ----------------------------------------------------------------------------
package ctluc_pkg;

  localparam logic [1:0] REQ_DOWN = 2'd0;
  localparam logic [1:0] REQ_MOVE = 2'd1;
  localparam logic [1:0] REQ_UP   = 2'd2;
  localparam logic [1:0] REQ_NOP  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int USAGE_BITS = 5;
  localparam logic [USAGE_BITS-1:0] USAGE_MAX = 5'd31;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SCAN    = 10'b0000000010,
    S_DECIDE  = 10'b0000000100,
    S_CMIN    = 10'b0000001000,
    S_CCOUNT  = 10'b0000010000,
    S_CPICK   = 10'b0000100000,
    S_CUPD    = 10'b0001000000,
    S_WRITE   = 10'b0010000000,
    S_OUT     = 10'b0100000000,
    S_CMOD    = 10'b1000000000
  } state_t;

endpackage

/* rtl/core/contact_tracker_least_used_color_core.sv */
// ----------------------------------------------------------------------------
// contact_tracker_least_used_color_core
// contact table with least-used color allocation and random tie break
// ----------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid/in_ready, request fields
// out     | output    | out_valid/out_ready, result fields
//
// from the accepting edge to out_valid: every request runs the entry scan and decide;
// a move writes its entry, an up reads and writes its color counter, a rejected or
// unused request goes straight to output, an accepted down runs three counter passes
// (minimum, tie count, pick) with the remainder step before the pick, then the update
// each memory is read one entry a cycle and its read data is registered
// reset clears valid bits and usage counts at once (no clearing pass)
// the result register holds while out_ready is low; in_ready rises once it is taken
module contact_tracker_least_used_color_core
  import ctluc_pkg::*;
#(
  parameter int MAX_CONTACTS = 16,
  parameter int NUM_COLORS   = 10,
  parameter int POS_BITS     = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_is_touch,
  input  logic [63:0] in_contact_id,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [7:0]  in_random_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_color_index,
  output logic        out_scene_changed,
  output logic [11:0] out_out_x,
  output logic [11:0] out_out_y
);

  `include "contact_tracker_least_used_color_core_defines.svh"

  localparam int SW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam int EW = 1 + 64 + 4 + 2 * POS_BITS;  // touch, key, color, pos

  // entry memory and usage counter memory
  logic [EW-1:0]         ent_mem [MAX_CONTACTS];
  logic [USAGE_BITS-1:0] use_mem [NUM_COLORS];
  logic [MAX_CONTACTS-1:0] valid_r;
  logic [NUM_COLORS-1:0]   use_nz_r; // marks counters written since reset

  state_t state_r;

  // latched request
  logic [1:0]          req_r;
  logic                touch_r;
  logic [63:0]         id_r;
  logic [POS_BITS-1:0] px_r, py_r;
  logic [7:0]          rnd_r;

  // scan bookkeeping
  logic [SW:0]   sidx_r;   // read address issued
  logic          rd_vld_r; // read data valid this cycle
  logic [SW-1:0] rd_slot_r;
  logic [EW-1:0] ent_q_r;
  logic          hit_r;
  logic [SW-1:0] hit_slot_r;
  logic [EW-1:0] hit_ent_r;
  logic          free_r;
  logic [SW-1:0] free_slot_r;

  // color passes
  logic [CW:0]           cidx_r;
  logic                  crd_vld_r;
  logic [CW-1:0]         crd_col_r;
  logic [USAGE_BITS-1:0] use_q_r;
  logic [USAGE_BITS:0]   min_r;
  logic [CW:0]           ties_r;
  logic [7:0]            pick_r;
  logic [CW-1:0]         col_r;
  logic                  picked_r;
  logic [2:0]            mbit_r;   // random bit consumed by the remainder step

  // result register
  logic                out_valid_r;
  logic [1:0]          o_st_r;
  logic [3:0]          o_col_r;
  logic                o_chg_r;
  logic [POS_BITS-1:0] o_x_r, o_y_r;

  assign in_ready          = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_status        = o_st_r;
  assign out_color_index   = o_col_r;
  assign out_scene_changed = o_chg_r;
  assign out_out_x         = 12'(o_x_r);
  assign out_out_y         = 12'(o_y_r);

  // field views of the registered read word
  logic                q_touch;
  logic [63:0]         q_key;
  assign q_touch = ent_q_r[EW-1];
  assign q_key   = ent_q_r[EW-2 -: 64];

  function automatic logic [3:0] ent_col(input logic [EW-1:0] e);
    return e[2*POS_BITS +: 4];
  endfunction

  // usage value seen by the counter passes (unwritten counters read zero)
  logic [USAGE_BITS-1:0] use_v;
  assign use_v = use_q_r;

  // remainder step: shift in one random bit, subtract the tie count if it fits
  logic [7:0] mod_sh;
  logic [7:0] ties_w;
  assign mod_sh = {pick_r[6:0], rnd_r[mbit_r]};
  assign ties_w = 8'(ties_r);

  // address and write controls
  logic                  ent_we;
  logic [SW-1:0]         ent_wa;
  logic [EW-1:0]         ent_wd;
  logic                  use_we;
  logic [CW-1:0]         use_wa;
  logic [USAGE_BITS-1:0] use_wd;
  logic [CW-1:0]         use_ra;
  logic                  use_hit;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_q_r <= ent_mem[sidx_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_q_r <= use_hit ? use_mem[use_ra] : '0;
  end

  assign use_hit = use_nz_r[use_ra];

  // decrement/increment helpers
  logic [USAGE_BITS-1:0] use_inc, use_dec;
  assign use_inc = (use_v < USAGE_MAX) ? use_v + 1'b1 : use_v;
  assign use_dec = (use_v != '0) ? use_v - 1'b1 : use_v;

  always_comb begin
    ent_we = 1'b0;
    ent_wa = hit_r ? hit_slot_r : free_slot_r;
    ent_wd = {touch_r, id_r, 4'(col_r), py_r, px_r};
    use_we = 1'b0;
    use_wa = col_r;
    use_wd = use_inc;
    use_ra = cidx_r[CW-1:0];
    if (state_r == S_WRITE) begin
      if (req_r == REQ_DOWN) begin
        ent_we = 1'b1;
        use_we = 1'b1;
      end else if (req_r == REQ_MOVE) begin
        ent_we = 1'b1;
        ent_wd = {touch_r, id_r, ent_col(hit_ent_r), py_r, px_r};
      end else begin
        use_we = 1'b1;
        use_wd = use_dec;
      end
    end
    if (state_r == S_CUPD) begin
      use_ra = col_r;
    end
  end

  logic scan_match;
  assign scan_match = rd_vld_r && valid_r[rd_slot_r] && q_touch == touch_r && q_key == id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      use_nz_r    <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      crd_vld_r   <= 1'b0;
      sidx_r      <= '0;
      cidx_r      <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (use_we) begin
        use_nz_r[use_wa] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r    <= in_req_type;
            touch_r  <= in_is_touch;
            id_r     <= in_contact_id;
            px_r     <= POS_BITS'(in_pos_x);
            py_r     <= POS_BITS'(in_pos_y);
            rnd_r    <= in_random_value;
            hit_r    <= 1'b0;
            free_r   <= 1'b0;
            sidx_r   <= '0;
            rd_vld_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, compare the word returned last cycle
          rd_vld_r  <= (sidx_r < (SW+1)'(MAX_CONTACTS));
          rd_slot_r <= sidx_r[SW-1:0];
          if (sidx_r < (SW+1)'(MAX_CONTACTS)) begin
            sidx_r <= sidx_r + 1'b1;
          end
          if (scan_match && !hit_r) begin
            hit_r      <= 1'b1;
            hit_slot_r <= rd_slot_r;
            hit_ent_r  <= ent_q_r;
          end
          if (rd_vld_r && !valid_r[rd_slot_r] && !free_r) begin
            free_r      <= 1'b1;
            free_slot_r <= rd_slot_r;
          end
          if (!rd_vld_r && sidx_r == (SW+1)'(MAX_CONTACTS)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cidx_r    <= '0;
          crd_vld_r <= 1'b0;
          min_r     <= {1'b1, {USAGE_BITS{1'b0}}};
          ties_r    <= '0;
          picked_r  <= 1'b0;
          o_chg_r   <= 1'b0;
          o_col_r   <= '0;
          o_x_r     <= '0;
          o_y_r     <= '0;
          o_st_r    <= ST_OK;
          priority if (req_r == REQ_DOWN) begin
            if (hit_r) begin
              o_st_r  <= ST_DUPLICATE;
              o_col_r <= ent_col(hit_ent_r);
              o_x_r   <= hit_ent_r[POS_BITS-1:0];
              o_y_r   <= hit_ent_r[2*POS_BITS-1:POS_BITS];
              state_r <= S_OUT;
            end else if (!free_r) begin
              o_st_r  <= ST_FULL;
              state_r <= S_OUT;
            end else begin
              state_r <= S_CMIN;
            end
          end else if (req_r == REQ_MOVE || req_r == REQ_UP) begin
            if (!hit_r) begin
              o_st_r  <= ST_NOT_FOUND;
              state_r <= S_OUT;
            end else begin
              o_chg_r <= 1'b1;
              o_col_r <= ent_col(hit_ent_r);
              if (req_r == REQ_MOVE) begin
                o_x_r   <= px_r;
                o_y_r   <= py_r;
                state_r <= S_WRITE;
              end else begin
                o_x_r   <= hit_ent_r[POS_BITS-1:0];
                o_y_r   <= hit_ent_r[2*POS_BITS-1:POS_BITS];
                valid_r[hit_slot_r] <= 1'b0;
                // stored color is always below NUM_COLORS
                col_r   <= CW'(ent_col(hit_ent_r));
                state_r <= S_CUPD;
              end
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_CMIN, S_CCOUNT, S_CPICK: begin
          // sweep the counters; one read issued, one value examined per cycle
          crd_vld_r <= (cidx_r < (CW+1)'(NUM_COLORS));
          crd_col_r <= cidx_r[CW-1:0];
          if (cidx_r < (CW+1)'(NUM_COLORS)) begin
            cidx_r <= cidx_r + 1'b1;
          end
          if (crd_vld_r) begin
            if (state_r == S_CMIN && {1'b0, use_v} < min_r) begin
              min_r <= {1'b0, use_v};
            end
            if (state_r == S_CCOUNT && {1'b0, use_v} == min_r) begin
              ties_r <= ties_r + 1'b1;
            end
            if (state_r == S_CPICK && {1'b0, use_v} == min_r && !picked_r) begin
              if (pick_r == '0) begin
                picked_r <= 1'b1;
                col_r    <= crd_col_r;
              end else begin
                pick_r <= pick_r - 1'b1;
              end
            end
          end
          if (!crd_vld_r && cidx_r == (CW+1)'(NUM_COLORS)) begin
            cidx_r <= '0;
            if (state_r == S_CMIN) begin
              state_r <= S_CCOUNT;
            end else if (state_r == S_CCOUNT) begin
              // random mod tie count, built from the eight random bits one at a time
              pick_r  <= '0;
              mbit_r  <= 3'd7;
              state_r <= S_CMOD;
            end else begin
              state_r <= S_CUPD;
            end
          end
        end
        S_CMOD: begin
          // restoring remainder, msb of the random draw first; ties is never zero
          pick_r <= (mod_sh >= ties_w) ? mod_sh - ties_w : mod_sh;
          mbit_r <= mbit_r - 1'b1;
          if (mbit_r == 3'd0) begin
            state_r <= S_CPICK;
          end
        end
        S_CUPD: begin
          // read the chosen counter; data ready next cycle
          state_r <= S_WRITE;
          if (req_r == REQ_DOWN) begin
            o_col_r <= 4'(col_r);
            o_chg_r <= 1'b1;
            o_x_r   <= px_r;
            o_y_r   <= py_r;
          end
        end
        S_WRITE: begin
          if (req_r == REQ_DOWN) begin
            valid_r[free_slot_r] <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result is presented only while the core is idle
  `CT_ASSERT(a_out_busy, !(out_valid_r && state_r != S_IDLE), "result while busy")
  // a new transaction is never taken while a result waits
  `CT_ASSERT(a_no_take, !(in_ready && out_valid_r), "ready with pending result")
  // a rejected request never reports a scene change
  `CT_ASSERT(a_rej, !(out_valid_r && o_st_r != ST_OK && o_chg_r), "change on reject")
  // every request produces its result after the output state
  `CT_ASSERT_NEXT(a_out_next, state_r == S_OUT, out_valid_r, "missing result")

endmodule
